// ===== sv/ckb_pkg.sv =====
// shared types and constants for the coincidence kernel backprojector
`timescale 1ns / 1ps
`default_nettype none
package ckb_pkg;

  localparam int MAP_ENTRIES = 1024;
  localparam int GROUP_SIZE  = 64;
  localparam int KERNEL_TAPS = 16;
  localparam int IMAGE_COLS  = 128;
  localparam int IMAGE_ROWS  = 64;
  localparam int CHAN_W      = 8;
  localparam int ROW_W       = GROUP_SIZE * CHAN_W;
  localparam int LOC_W       = 6;

  typedef enum logic [1:0] {
    ACT_MAP_LOAD  = 2'd0,
    ACT_KERN_LOAD = 2'd1,
    ACT_EVENT     = 2'd2,
    ACT_PIX_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP_WB,
    S_LOOK0,
    S_LOOK1,
    S_TAP,
    S_PIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [LOC_W-1:0] index;
  } match_t;

endpackage
`default_nettype wire

// ===== sv/ckb_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ckb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/ckb_search.sv =====
// parallel channel search over one map group, lowest entry wins
`timescale 1ns / 1ps
`default_nettype none
module ckb_search (
  input  wire logic [ckb_pkg::ROW_W-1:0] row,
  input  wire logic                      en,
  input  wire logic [5:0]                chan,
  output ckb_pkg::match_t                m
);

  always_comb begin
    m = '0;
    for (int i = ckb_pkg::GROUP_SIZE - 1; i >= 0; i--) begin
      if (en && row[i*ckb_pkg::CHAN_W +: ckb_pkg::CHAN_W] == {2'b00, chan}) begin
        m.found = 1'b1;
        m.index = ckb_pkg::LOC_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/coincidence_kernel_backprojector_unit.sv =====
// top level of the coincidence kernel backprojector
// usage:
//   input channel (in_valid / in_stall) carries one transaction per action:
//   map load, kernel load, coincidence event or pixel read. output channel
//   (out_valid / out_stall) returns exactly one result transaction for each.
//   the channel map lives in a ram of 64-entry rows, one row per group, so a
//   lookup is one row read searched in parallel. the image lives in a ram
//   with one write and one read port; each event does up to 16 read-modify-write
//   updates, the read of one tap overlapping the write of the previous one.
// sequencing: kernel load goes straight to the result, map load reads the row
//   and writes it back, pixel read reads one image word, event does two row
//   reads then the tap updates; one transaction is processed at a time
// reset: a clearing pass writes zero to every image word, with in_stall
//   high; map rows and kernel taps clear at once
// stall: the result waits in the output register; the next transaction is
//   still accepted, and the block holds its finished result if the output
//   register is still occupied
`timescale 1ns / 1ps
`default_nettype none
module coincidence_kernel_backprojector_unit #(
  parameter int MAP_ENTRIES = ckb_pkg::MAP_ENTRIES,
  parameter int IMAGE_ROWS  = ckb_pkg::IMAGE_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [9:0]  first_id,
  input  wire logic [9:0]  second_id,
  input  wire logic [12:0] slot,
  input  wire logic [31:0] load_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      pixel_count,
  output logic [5:0]       sum_col,
  output logic [4:0]       sum_row
);

  localparam int MAP_ROWS = MAP_ENTRIES / ckb_pkg::GROUP_SIZE;
  localparam int MAP_RAW  = $clog2(MAP_ROWS);
  localparam int IMG_SIZE = IMAGE_ROWS * ckb_pkg::IMAGE_COLS;
  localparam int IMG_AW   = $clog2(IMG_SIZE);
  localparam int TAP_W    = $clog2(ckb_pkg::KERNEL_TAPS);

  ckb_pkg::state_t  state, state_next;
  ckb_pkg::action_t act_q;
  logic [9:0]       id1_q;
  logic [12:0]      slot_q;
  logic [7:0]       val_q;

  // map ram ports
  logic                      map_we;
  logic [MAP_RAW-1:0]        map_waddr, map_raddr;
  logic [ckb_pkg::ROW_W-1:0] map_wdata, map_rdata, row_eff;
  logic                      map_rd_in, map_rd_vld;
  logic                      rd_inrange, rd_vld;
  logic [MAP_ROWS-1:0]       map_vld;

  // image ram ports
  logic              img_we;
  logic [IMG_AW-1:0] img_waddr, img_raddr, img_rdata_addr_unused;
  logic [31:0]       img_wdata, img_rdata;

  logic [31:0] kern [ckb_pkg::KERNEL_TAPS];

  logic [5:0]        loc, loc_eff;
  logic [4:0]        x0;
  logic [3:0]        y0;
  logic [5:0]        sx;
  logic [4:0]        sy;
  logic [TAP_W:0]    cnt;
  logic              pend;
  logic [TAP_W-1:0]  pend_tap;
  logic [IMG_AW-1:0] pend_addr;
  logic [IMG_AW-1:0] clr_cnt;
  logic [31:0]       res_pix;

  logic [7:0]        tap_r, tap_c;
  logic [13:0]       tap_full;
  logic [IMG_AW-1:0] tap_addr;
  logic              tap_ok;
  logic              accept, out_free;
  logic [5:0]        search_chan;
  logic [4:0]        x1;
  logic [3:0]        y1;

  ckb_pkg::match_t m;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ckb_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  ckb_ram #(.WIDTH(ckb_pkg::ROW_W), .DEPTH(MAP_ROWS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ckb_ram #(.WIDTH(32), .DEPTH(IMG_SIZE)) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  // a row never written reads as all zero
  assign row_eff = rd_vld ? map_rdata : '0;

  // search the row of the first id in look0, of the second id in look1
  assign search_chan = (state == ckb_pkg::S_LOOK1) ? id1_q[5:0] : slot_q[5:0];

  ckb_search u_search (
    .row  (row_eff),
    .en   (rd_inrange),
    .chan (search_chan),
    .m    (m)
  );

  assign loc_eff = m.found ? m.index : loc;
  assign x1 = {id1_q[8], id1_q[6], loc_eff[2:0]};
  assign y1 = {id1_q[7], loc_eff[5:3]};

  // tap position: base at (sum / 2) * 4 plus 2 for odd sums
  assign tap_r    = {2'b00, sy[4:1], sy[0], 1'b0} + {6'd0, cnt[3:2]};
  assign tap_c    = {1'b0, sx[5:1], sx[0], 1'b0} + {6'd0, cnt[1:0]};
  assign tap_ok   = (32'(tap_r) < IMAGE_ROWS) && (32'(tap_c) < ckb_pkg::IMAGE_COLS);
  assign tap_full = {tap_r[6:0], tap_c[6:0]};
  assign tap_addr = tap_full[IMG_AW-1:0];
  assign img_rdata_addr_unused = '0;

  always_comb begin
    state_next = state;
    map_we     = 1'b0;
    map_waddr  = slot_q[6 +: MAP_RAW];
    map_wdata  = row_eff;
    map_wdata[slot_q[5:0]*ckb_pkg::CHAN_W +: ckb_pkg::CHAN_W] = val_q;
    map_raddr  = slot[6 +: MAP_RAW];
    map_rd_in  = 1'b0;
    img_we     = 1'b0;
    img_waddr  = pend_addr;
    img_wdata  = img_rdata + kern[pend_tap];
    img_raddr  = tap_addr;
    unique case (state)
      ckb_pkg::S_CLEAR: begin
        img_we    = 1'b1;
        img_waddr = clr_cnt;
        img_wdata = '0;
        if (clr_cnt == IMG_AW'(IMG_SIZE - 1)) begin
          state_next = ckb_pkg::S_IDLE;
        end
      end
      ckb_pkg::S_IDLE: begin
        if (accept) begin
          unique case (ckb_pkg::action_t'(action))
            ckb_pkg::ACT_MAP_LOAD: begin
              map_raddr = slot[6 +: MAP_RAW];
              map_rd_in = (32'(slot) < MAP_ENTRIES);
              state_next = map_rd_in ? ckb_pkg::S_MAP_WB : ckb_pkg::S_DONE;
            end
            ckb_pkg::ACT_KERN_LOAD: begin
              state_next = ckb_pkg::S_DONE;
            end
            ckb_pkg::ACT_EVENT: begin
              map_raddr  = first_id[6 +: MAP_RAW];
              map_rd_in  = (32'(first_id[9:6]) < MAP_ROWS);
              state_next = ckb_pkg::S_LOOK0;
            end
            ckb_pkg::ACT_PIX_READ: begin
              img_raddr  = IMG_AW'(slot);
              state_next = (32'(slot) < IMG_SIZE) ? ckb_pkg::S_PIX : ckb_pkg::S_DONE;
            end
            default: state_next = ckb_pkg::S_DONE;
          endcase
        end
      end
      ckb_pkg::S_MAP_WB: begin
        map_we     = 1'b1;
        state_next = ckb_pkg::S_DONE;
      end
      ckb_pkg::S_LOOK0: begin
        map_raddr  = id1_q[6 +: MAP_RAW];
        map_rd_in  = (32'(id1_q[9:6]) < MAP_ROWS);
        state_next = ckb_pkg::S_LOOK1;
      end
      ckb_pkg::S_LOOK1: begin
        state_next = ckb_pkg::S_TAP;
      end
      ckb_pkg::S_TAP: begin
        img_we = pend;
        if (cnt == (TAP_W+1)'(ckb_pkg::KERNEL_TAPS)) begin
          state_next = ckb_pkg::S_DONE;
        end
      end
      ckb_pkg::S_PIX: begin
        state_next = ckb_pkg::S_DONE;
      end
      ckb_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ckb_pkg::S_IDLE;
        end
      end
      default: state_next = ckb_pkg::S_IDLE;
    endcase
    map_rd_vld = map_rd_in && map_vld[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      map_vld   <= '0;
      loc       <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
      for (int k = 0; k < ckb_pkg::KERNEL_TAPS; k++) begin
        kern[k] <= '0;
      end
    end else begin
      if (state == ckb_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept && ckb_pkg::action_t'(action) == ckb_pkg::ACT_KERN_LOAD &&
          slot[12:TAP_W] == '0) begin
        kern[slot[TAP_W-1:0]] <= load_value;
      end
      if (map_we) begin
        map_vld[map_waddr] <= 1'b1;
      end
      if (state == ckb_pkg::S_LOOK0 || state == ckb_pkg::S_LOOK1) begin
        loc <= loc_eff;
      end
      if (state == ckb_pkg::S_LOOK1) begin
        cnt  <= '0;
        pend <= 1'b0;
      end
      if (state == ckb_pkg::S_TAP) begin
        if (cnt != (TAP_W+1)'(ckb_pkg::KERNEL_TAPS)) begin
          cnt  <= cnt + 1'b1;
          pend <= tap_ok;
        end else begin
          pend <= 1'b0;
        end
      end
      if (state == ckb_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_inrange <= map_rd_in;
    rd_vld     <= map_rd_vld;
    if (accept) begin
      act_q   <= ckb_pkg::action_t'(action);
      id1_q   <= second_id;
      slot_q  <= (ckb_pkg::action_t'(action) == ckb_pkg::ACT_EVENT) ?
                 {3'd0, first_id} : slot;
      val_q   <= load_value[7:0];
      res_pix <= '0;
    end
    if (state == ckb_pkg::S_LOOK0) begin
      x0 <= {slot_q[8], slot_q[6], loc_eff[2:0]};
      y0 <= {~slot_q[7], loc_eff[5:3]};
    end
    if (state == ckb_pkg::S_LOOK1) begin
      sx <= {1'b0, x0} + {1'b0, x1};
      sy <= {1'b0, y0} + {1'b0, y1};
    end
    if (state == ckb_pkg::S_TAP && cnt != (TAP_W+1)'(ckb_pkg::KERNEL_TAPS)) begin
      pend_addr <= tap_addr + img_rdata_addr_unused;
      pend_tap  <= cnt[TAP_W-1:0];
    end
    if (state == ckb_pkg::S_PIX) begin
      res_pix <= img_rdata;
    end
    if (state == ckb_pkg::S_DONE && out_free) begin
      pixel_count <= (act_q == ckb_pkg::ACT_PIX_READ) ? res_pix : '0;
      sum_col     <= (act_q == ckb_pkg::ACT_EVENT) ? sx : '0;
      sum_row     <= (act_q == ckb_pkg::ACT_EVENT) ? sy : '0;
    end
  end

  // input held off for the whole clearing pass
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ckb_pkg::S_CLEAR) |-> in_stall)
    else $error("input accepted during image clear");

  // image writes only from the clearing pass or the tap updates
  a_img_write_src: assert property (@(posedge clk) disable iff (rst)
    img_we |-> (state == ckb_pkg::S_CLEAR || state == ckb_pkg::S_TAP))
    else $error("image write outside clear or tap phase");

  // an accepted transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ckb_pkg::S_IDLE))
    else $error("accepted transaction not processed");

  // map writes only as the second half of a map load
  a_map_write: assert property (@(posedge clk) disable iff (rst)
    map_we |-> (act_q == ckb_pkg::ACT_MAP_LOAD && $past(state) == ckb_pkg::S_IDLE))
    else $error("map write without a map load");

endmodule
`default_nettype wire

// ===== tb/tb_coincidence_kernel_backprojector_unit.sv =====
// self-checking testbench for the coincidence kernel backprojector unit
`timescale 1ns / 1ps
module tb_coincidence_kernel_backprojector_unit;
  import ckb_pkg::*;

  localparam int IMG_WORDS = IMAGE_ROWS * IMAGE_COLS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    action_t     act;
    logic [9:0]  id_a;
    logic [9:0]  id_b;
    logic [12:0] slot;
    logic [31:0] value;
  } bp_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [5:0]  col;
    logic [4:0]  row;
  } bp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = '0;
  logic [9:0]  first_id = '0;
  logic [9:0]  second_id = '0;
  logic [12:0] slot = '0;
  logic [31:0] load_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pixel_count;
  logic [5:0]  sum_col;
  logic [4:0]  sum_row;

  coincidence_kernel_backprojector_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .first_id(first_id), .second_id(second_id),
    .slot(slot), .load_value(load_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_count(pixel_count), .sum_col(sum_col), .sum_row(sum_row)
  );

  // predictor copy of the block state
  logic [7:0]  chan_tab [MAP_ENTRIES];
  logic [31:0] taps [KERNEL_TAPS];
  logic [31:0] image_acc [IMG_WORDS];
  logic [5:0]  hit_loc;

  bp_item_t   pending_items[$];
  bp_result_t expected_results[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         events_sent = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_off = 1'b0;

  initial forever #5 clk = ~clk;

  // map group search: lowest matching entry wins, miss keeps the old location
  task automatic search_group(input logic [9:0] id);
    int base;
    base = int'(id) & ~(GROUP_SIZE - 1);
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (base + i < MAP_ENTRIES && chan_tab[base + i] == {2'b00, id[5:0]}) begin
        hit_loc = 6'(i);
        return;
      end
    end
  endtask

  task automatic backproject(input bp_item_t it, output bp_result_t res);
    int x0, y0, x1, y1, sx, sy, r0, c0, r, c;
    res = '0;
    case (it.act)
      ACT_MAP_LOAD: if (it.slot < MAP_ENTRIES) chan_tab[it.slot] = it.value[7:0];
      ACT_KERN_LOAD: if (it.slot < KERNEL_TAPS) taps[it.slot] = it.value;
      ACT_PIX_READ: if (it.slot < IMG_WORDS) res.count = image_acc[it.slot];
      default: begin
        search_group(it.id_a);
        x0 = it.id_a[8] * 16 + it.id_a[6] * 8 + hit_loc[2:0];
        y0 = (1 - it.id_a[7]) * 8 + hit_loc[5:3];
        search_group(it.id_b);
        x1 = it.id_b[8] * 16 + it.id_b[6] * 8 + hit_loc[2:0];
        y1 = it.id_b[7] * 8 + hit_loc[5:3];
        sx = x0 + x1;
        sy = y0 + y1;
        r0 = (sy / 2) * 4 + ((sy % 2) ? 2 : 0);
        c0 = (sx / 2) * 4 + ((sx % 2) ? 2 : 0);
        for (int t = 0; t < KERNEL_TAPS; t++) begin
          r = r0 + t / 4;
          c = c0 + t % 4;
          if (r < IMAGE_ROWS && c < IMAGE_COLS)
            image_acc[r * IMAGE_COLS + c] += taps[t];
        end
        res.col = 6'(sx);
        res.row = 5'(sy);
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
  endtask

  function automatic bp_item_t make_item(action_t a, int ida, int idb, int s, logic [31:0] v);
    bp_item_t it;
    it.act = a; it.id_a = 10'(ida); it.id_b = 10'(idb); it.slot = 13'(s); it.value = v;
    return it;
  endfunction

  // random mix, mostly map loads and events with matching channels so lookups hit
  function automatic bp_item_t random_item();
    int pick;
    bp_item_t it;
    pick = $urandom_range(0, 99);
    it.id_a = 10'($urandom);
    it.id_b = 10'($urandom);
    it.value = $urandom;
    it.slot = 13'($urandom);
    if (pick < 25) begin
      it.act = ACT_MAP_LOAD;
      if (pick < 22) begin
        it.slot = 13'($urandom_range(0, MAP_ENTRIES - 1));
        if (pick < 18) it.value[7:0] = 8'($urandom_range(0, 63));
      end
    end else if (pick < 35) begin
      it.act = ACT_KERN_LOAD;
      if (pick < 33) it.slot = 13'($urandom_range(0, KERNEL_TAPS - 1));
    end else if (pick < 75) begin
      it.act = ACT_EVENT;
    end else begin
      it.act = ACT_PIX_READ;
      if (pick < 95) it.slot = 13'($urandom_range(0, IMG_WORDS - 1));
    end
    return it;
  endfunction

  // driver: holds the payload until accepted, random gaps between transactions
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid && !in_stall) begin
        bp_result_t r;
        bp_item_t   done;
        done = pending_items.pop_front();
        backproject(done, r);
        expected_results.push_back(r);
        if (done.act == ACT_EVENT) events_sent++;
      end
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        action     <= pending_items[0].act;
        first_id   <= pending_items[0].id_a;
        second_id  <= pending_items[0].id_b;
        slot       <= pending_items[0].slot;
        load_value <= pending_items[0].value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compares every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", pixel_count, 0);
        end else begin
          bp_result_t want;
          want = expected_results.pop_front();
          if (pixel_count !== want.count) report("pixel_count", pixel_count, want.count);
          if (sum_col !== want.col) report("sum_col", 32'(sum_col), 32'(want.col));
          if (sum_row !== want.row) report("sum_row", 32'(sum_row), 32'(want.row));
        end
        results_seen++;
      end
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // long receiver hold-off in its own process so the block backs up
  initial begin
    wait (!rst);
    wait (events_sent > 40);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int phase_len;
    foreach (chan_tab[i]) chan_tab[i] = '0;
    foreach (taps[i]) taps[i] = '0;
    foreach (image_acc[i]) image_acc[i] = '0;
    hit_loc = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: miss after reset, loads, extremes, out-of-range slots, wraparound
    pending_items.push_back(make_item(ACT_EVENT, 0, 1023, 0, 0));
    pending_items.push_back(make_item(ACT_PIX_READ, 0, 0, 0, 0));
    for (int t = 0; t < KERNEL_TAPS; t++)
      pending_items.push_back(make_item(ACT_KERN_LOAD, 0, 0, t, 32'hFFFF_FFF0 + t));
    pending_items.push_back(make_item(ACT_KERN_LOAD, 0, 0, 8191, 32'h1234));
    pending_items.push_back(make_item(ACT_MAP_LOAD, 0, 0, 1023, 32'hFFFF_FF3F));
    pending_items.push_back(make_item(ACT_MAP_LOAD, 0, 0, 8191, 32'h5));
    pending_items.push_back(make_item(ACT_EVENT, 1023, 1023, 0, 0));
    pending_items.push_back(make_item(ACT_EVENT, 1023, 0, 0, 0));
    pending_items.push_back(make_item(ACT_PIX_READ, 0, 0, IMG_WORDS - 1, 0));
    pending_items.push_back(make_item(ACT_PIX_READ, 0, 0, 8191, 0));
    pending_items.push_back(make_item(ACT_PIX_READ, 0, 0, 4 * IMAGE_COLS + 4, 0));
    wait_drained();

    // random phases with different idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      phase_len = (ph == 0) ? 250 : 165;
      for (int n = 0; n < phase_len; n++) pending_items.push_back(random_item());
      // finish each phase at full speed once under half its items remain
      wait (pending_items.size() < phase_len / 2);
      send_idle_pct = 0; recv_stall_pct = 0;
      wait_drained();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d results, %0d coincidence events, with idle and stall mixes",
             results_seen, events_sent);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/ckb_pkg.sv
sv/ckb_ram.sv
sv/ckb_search.sv
sv/coincidence_kernel_backprojector_unit.sv
tb/tb_coincidence_kernel_backprojector_unit.sv
